>>> src/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared request codes, status codes and the control bundle that the
// request decoder hands to the cell chain and the top level.
// ----------------------------------------------------------------------------
package plist_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEG   = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Decoded request. The ins, del and clr flags are already qualified by
    // the transfer and by an ok status; take marks a request whose result
    // carries the addressed entry.
    typedef struct packed {
        logic    ins;
        logic    del;
        logic    clr;
        logic    take;
        status_t status;
    } ctrl_t;

endpackage

>>> src/plist_ctrl.sv
// ----------------------------------------------------------------------------
// plist_ctrl
// Request decoder: checks the position against the current length and
// produces the status, the target cell index and the cell commands.
// ----------------------------------------------------------------------------
module plist_ctrl
    import plist_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic          accept,
    input  logic [1:0]    req_type,
    input  logic [15:0]   position,
    input  logic [CW-1:0] count,
    output ctrl_t         ctrl,
    output logic [IW-1:0] index
);

    op_t         op;
    logic        pos_neg;
    logic [14:0] pos_mag;
    logic [14:0] cnt_w;
    logic        past_end;
    logic        full;

    assign op       = op_t'(req_type);
    assign pos_neg  = position[15];
    assign pos_mag  = position[14:0];
    assign cnt_w    = 15'(count);
    assign past_end = (pos_mag >= cnt_w);
    assign full     = (count == CW'(CAPACITY));

    always_comb
    begin
        ctrl        = '0;
        ctrl.status = ST_OK;
        // An insert past the end appends at the current length.
        index       = IW'(past_end ? cnt_w : pos_mag);
        unique case (op)
            OP_INSERT:
            begin
                if (pos_neg)
                    ctrl.status = ST_NEG;
                else if (full)
                    ctrl.status = ST_FULL;
                else
                    ctrl.ins = accept;
            end
            OP_READ:
            begin
                if (pos_neg)
                    ctrl.status = ST_NEG;
                else if (past_end)
                    ctrl.status = ST_RANGE;
                else
                    ctrl.take = 1'b1;
            end
            OP_DELETE:
            begin
                if (pos_neg)
                    ctrl.status = ST_NEG;
                else if (past_end)
                    ctrl.status = ST_RANGE;
                else
                begin
                    ctrl.take = 1'b1;
                    ctrl.del  = accept;
                end
            end
            OP_CLEAR:
            begin
                ctrl.clr = accept;
            end
        endcase
    end

endmodule

>>> src/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell
// One list slot. On an insert it takes its left neighbor's entry when it lies
// behind the target, or the new value at the target; on a delete it takes its
// right neighbor's entry from the target onward.
// ----------------------------------------------------------------------------
module plist_cell
    import plist_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 4,
    parameter int SLOT       = 0
)
(
    input  logic                  clk,
    input  ctrl_t                 ctrl,
    input  logic [IW-1:0]         index,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] sel_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(SLOT);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  behind;

    assign hit    = (MY_IDX == index);
    assign behind = (MY_IDX > index);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (behind)
                data_next = left_data;
            else if (hit)
                data_next = din;
        end
        else if (ctrl.del)
        begin
            if (behind || hit)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = hit ? data_reg : '0;

endmodule

>>> src/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list with insert, read, delete and clear by position.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (req_type, position, value_in) and each
// request produces exactly one transfer on the rsp channel (status, value_out,
// length). A transfer happens on a rising edge where valid is high and stall
// is low. The list is a row of CAPACITY cells; every cell compares its own
// slot number with the target index and shifts from a neighbor or holds, so
// the whole list moves at once. The result is registered: it shows on rsp
// in the cycle after the request transfer, and with rsp_stall low the unit
// takes one request every cycle. The only limit on throughput is the
// single output register: while a result sits on rsp and rsp_stall is high,
// req_stall is raised and the request side waits. Read and delete return the
// entry that stood at the position before the request. A negative position,
// a read or delete at or past the length, and an insert into a full list
// leave the list unchanged and return an error status with value zero.
// Reset clears the length and the output valid; cell contents are not reset
// and are never returned before they are written. There is no clearing pass.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
    import plist_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] position,
    input  logic [31:0] value_in,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [4:0]  length
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  accept;
    ctrl_t                 ctrl;
    logic [IW-1:0]         index;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [63:0]           din_wide;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_sel  [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]           rd_wide;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    status_t               status_reg;
    logic [31:0]           value_reg;
    logic [4:0]            length_reg;

    // The output register is the only buffer: a new request is taken when it
    // is empty or being emptied in the same cycle.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // The input value is limited to the cell width.
    assign din_wide = 64'(value_in);
    assign din      = din_wide[DATA_WIDTH-1:0];

    plist_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .accept   (accept),
        .req_type (req_type),
        .position (position),
        .count    (count_reg),
        .ctrl     (ctrl),
        .index    (index)
    );

    // The chain of cells. The ends see zero from outside the list; the front
    // cell never shifts from the left, and a zero shifted into the last cell
    // on a delete lies past the new length.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_front
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_back
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        plist_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .SLOT       (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .index      (index),
            .din        (din),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g]),
            .sel_data   (cell_sel[g])
        );
    end

    // Each cell drives zero unless it is the target, so the addressed entry
    // is the OR of all cell outputs.
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_data = rd_data | cell_sel[i];
        end
    end

    assign rd_wide = 64'(rd_data);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clr)
            count_next = '0;
        else if (ctrl.ins)
            count_next = count_reg + CW'(1);
        else if (ctrl.del)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload: loaded only when a request is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= ctrl.status;
            value_reg  <= ctrl.take ? rd_wide[31:0] : 32'd0;
            length_reg <= 5'(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign value_out = value_reg;
    assign length    = length_reg;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list length exceeds capacity");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted insert did not grow the list by one");

    a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctrl.status == ST_FULL |-> count_reg == CW'(CAPACITY))
        else $error("full status reported on a list that is not full");

    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg != ST_OK |-> value_reg == 32'd0)
        else $error("error result carries a nonzero value");
`endif

endmodule
